[src/spx_pkg.sv]
// ----------------------------------------------------------------------------
// spx_pkg
// Shared types and constants of the SPIR-V entry point extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package spx_pkg;

    localparam logic [31:0] SPV_MAGIC       = 32'h0723_0203;
    localparam logic [15:0] OP_ENTRY_POINT  = 16'd15;
    localparam logic [2:0]  HEADER_WORDS    = 3'd5;
    localparam logic [15:0] MIN_ENTRY_WORDS = 16'd4;
    localparam logic [15:0] NAME_FIRST_WORD = 16'd3;
    localparam logic [15:0] MODEL_WORD      = 16'd1;
    localparam int          COUNT_SHIFT     = 16;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_OK         = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_ZERO_COUNT = 3'd3,
        ST_OVERRUN    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_NAME  = 2'd2
    } record_kind_t;

    typedef struct packed {
        logic [2:0]  header_position;
        logic [15:0] words_remaining;
        logic [15:0] offset_in_instruction;
        logic        inside_entry_point;
        logic        name_finished;
        status_t     error_code;
    } parse_state_t;

    typedef struct packed {
        record_kind_t record_kind;
        logic [31:0]  execution_model;
        logic [31:0]  name_chars;
        logic [2:0]   char_count;
        logic         name_complete;
        status_t      status;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        header_position:       3'd0,
        words_remaining:       16'd0,
        offset_in_instruction: 16'd0,
        inside_entry_point:    1'b0,
        name_finished:         1'b0,
        error_code:            ST_RUNNING
    };

endpackage

`default_nettype wire

[src/spx_name_scan.sv]
// ----------------------------------------------------------------------------
// spx_name_scan
// Scans one word for the first NUL byte and keeps the bytes before it.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_name_scan
(
    input  wire logic [31:0] word,
    output logic      [31:0] chars,
    output logic      [2:0]  count,
    output logic             nul
);

    always_comb
    begin
        logic seen;
        seen  = 1'b0;
        chars = 32'd0;
        count = 3'd0;
        for (int b = 0; b < 4; b++)
        begin
            if (word[b*8 +: 8] == 8'd0)
            begin
                seen = 1'b1;
            end
            if (!seen)
            begin
                chars[b*8 +: 8] = word[b*8 +: 8];
                count           = count + 3'd1;
            end
        end
        nul = seen;
    end

endmodule

`default_nettype wire

[src/spx_parse_step.sv]
// ----------------------------------------------------------------------------
// spx_parse_step
// Next parse state and result for one module word.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_parse_step
(
    input  wire spx_pkg::parse_state_t state,
    input  wire logic [31:0]           word,
    input  wire logic                  last,
    output spx_pkg::parse_state_t      state_next,
    output spx_pkg::result_t           result
);

    logic [31:0] scan_chars;
    logic [2:0]  scan_count;
    logic        scan_nul;

    spx_name_scan u_scan
    (
        .word  (word),
        .chars (scan_chars),
        .count (scan_count),
        .nul   (scan_nul)
    );

    always_comb
    begin
        spx_pkg::parse_state_t nxt;
        spx_pkg::result_t      res;
        logic [15:0]           wc;
        logic [15:0]           op;

        nxt = state;
        res = '{
            record_kind:     spx_pkg::KIND_NONE,
            execution_model: 32'd0,
            name_chars:      32'd0,
            char_count:      3'd0,
            name_complete:   1'b0,
            status:          spx_pkg::ST_RUNNING
        };
        wc = word[31:spx_pkg::COUNT_SHIFT];
        op = word[15:0];

        if (state.error_code == spx_pkg::ST_RUNNING)
        begin
            if (state.header_position < spx_pkg::HEADER_WORDS)
            begin
                if (state.header_position == 3'd0 && word != spx_pkg::SPV_MAGIC)
                begin
                    nxt.error_code = spx_pkg::ST_BAD_HEADER;
                end
                else
                begin
                    nxt.header_position = state.header_position + 3'd1;
                end
            end
            else if (state.words_remaining == 16'd0)
            begin
                // instruction start word
                if (wc == 16'd0)
                begin
                    nxt.error_code = spx_pkg::ST_ZERO_COUNT;
                end
                else
                begin
                    nxt.words_remaining       = wc - 16'd1;
                    nxt.offset_in_instruction = 16'd1;
                    nxt.inside_entry_point    = (op == spx_pkg::OP_ENTRY_POINT)
                                              && (wc >= spx_pkg::MIN_ENTRY_WORDS);
                    nxt.name_finished         = 1'b0;
                end
            end
            else
            begin
                nxt.words_remaining       = state.words_remaining - 16'd1;
                nxt.offset_in_instruction = state.offset_in_instruction + 16'd1;
                if (state.inside_entry_point)
                begin
                    if (state.offset_in_instruction == spx_pkg::MODEL_WORD)
                    begin
                        res.record_kind     = spx_pkg::KIND_ENTRY;
                        res.execution_model = word;
                    end
                    else if (state.offset_in_instruction >= spx_pkg::NAME_FIRST_WORD
                             && !state.name_finished)
                    begin
                        res.record_kind   = spx_pkg::KIND_NAME;
                        res.name_chars    = scan_chars;
                        res.char_count    = scan_count;
                        res.name_complete = scan_nul || (nxt.words_remaining == 16'd0);
                        if (res.name_complete)
                        begin
                            nxt.name_finished = 1'b1;
                        end
                    end
                end
            end

            if (last && nxt.error_code == spx_pkg::ST_RUNNING)
            begin
                if (nxt.header_position < spx_pkg::HEADER_WORDS)
                begin
                    nxt.error_code = spx_pkg::ST_BAD_HEADER;
                end
                else if (nxt.words_remaining != 16'd0)
                begin
                    nxt.error_code = spx_pkg::ST_OVERRUN;
                end
            end
        end

        if (nxt.error_code != spx_pkg::ST_RUNNING)
        begin
            res.status = nxt.error_code;
        end
        else
        begin
            res.status = last ? spx_pkg::ST_OK : spx_pkg::ST_RUNNING;
        end

        // keep records formed on an overrun word, drop them on other errors
        if (nxt.error_code != spx_pkg::ST_RUNNING && nxt.error_code != spx_pkg::ST_OVERRUN)
        begin
            res.record_kind     = spx_pkg::KIND_NONE;
            res.execution_model = 32'd0;
            res.name_chars      = 32'd0;
            res.char_count      = 3'd0;
            res.name_complete   = 1'b0;
        end

        if (last)
        begin
            nxt = spx_pkg::STATE_RESET;
        end

        state_next = nxt;
        result     = res;
    end

endmodule

`default_nettype wire

[src/spirv_entry_point_extractor_core.sv]
// ----------------------------------------------------------------------------
// spirv_entry_point_extractor_core
// Streams a SPIR-V module and reports entry point models and names.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one module word per item in s_tdata, s_tlast on the final
//   word of the module. Master channel: exactly one result item per input
//   item, in order. m_tuser carries the record kind (none, entry begins,
//   name chunk), m_tlast marks the chunk that ends a name, m_tdata carries
//   the execution model, name bytes, byte count and status.
//   Path: an input item is held in the input register, then the result
//   register, whose valid bit drives m_tvalid. Throughput: one item per
//   cycle while m_tready stays high; the per-word work is a four-byte NUL
//   scan and 16-bit counter updates between the two registers.
//   Stall: when m_tready is low the result register holds, the input
//   register fills, and s_tready drops once both are occupied; nothing is
//   lost or repeated.
//   Reset: rst_n clears both valid bits and the parse state; the next word
//   is taken as the magic number of a new module. The parse state also
//   returns to reset after every final word, so modules follow back to back.
// ----------------------------------------------------------------------------
`default_nettype none

module spirv_entry_point_extractor_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] code_word
    input  wire logic        s_tlast,   // last_word

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] execution_model, [63:32] name_chars,
                                        // [66:64] char_count, [69:67] status, [71:70] zero
    output logic [1:0]       m_tuser,   // [1:0] record_kind
    output logic             m_tlast    // name_complete
);

    // input register
    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        in_last_reg;

    // result register
    logic              out_valid_reg;
    spx_pkg::result_t  out_reg;

    // parse state
    spx_pkg::parse_state_t state_reg;
    spx_pkg::parse_state_t state_next;
    spx_pkg::result_t      result_next;

    logic out_free;
    logic advance;
    logic accept;

    // advance the input item into the result register when that slot frees up
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    spx_parse_step u_step
    (
        .state      (state_reg),
        .word       (in_word_reg),
        .last       (in_last_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= spx_pkg::STATE_RESET;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.record_kind;
    assign m_tlast  = out_reg.name_complete;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.char_count,
                       out_reg.name_chars, out_reg.execution_model};

    // a chunk that stops short of four bytes hit a NUL, so it ends the name
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.record_kind == spx_pkg::KIND_NAME && out_reg.char_count != 3'd4)
        |-> out_reg.name_complete)
    else $error("short name chunk not marked complete");

    // only name chunks carry bytes or the end-of-name mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.record_kind != spx_pkg::KIND_NAME)
        |-> (!out_reg.name_complete && out_reg.char_count == 3'd0))
    else $error("name fields set on a non-name record");

    // the final word of a module rearms the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg)
        |=> (state_reg.header_position == 3'd0
             && state_reg.words_remaining == 16'd0
             && state_reg.error_code == spx_pkg::ST_RUNNING))
    else $error("parse state not cleared after final word");

    // header counter never passes the header length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.header_position <= spx_pkg::HEADER_WORDS)
    else $error("header position out of range");

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for spirv_entry_point_extractor_core: a short table of
// hand-built modules, then a long run of random modules, mostly well formed,
// checked item by item against a behavioral parser, under random back
// pressure on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import spx_pkg::*;

    // One row of stimulus; fixed rows carry a hand-typed expected result.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        fixed;
        result_t     want;
    } word_row_t;

    localparam result_t RES_IDLE     = '{KIND_NONE, 32'h0, 32'h0, 3'd0, 1'b0, ST_RUNNING};
    localparam result_t RES_BAD_HDR  = '{KIND_NONE, 32'h0, 32'h0, 3'd0, 1'b0, ST_BAD_HEADER};
    localparam result_t RES_ZERO_CNT = '{KIND_NONE, 32'h0, 32'h0, 3'd0, 1'b0, ST_ZERO_COUNT};
    localparam result_t RES_CUT_MAIN = '{KIND_NAME, 32'h0, 32'h6E69_616D, 3'd4, 1'b0,
                                         ST_OVERRUN};
    localparam result_t RES_EMPTY_OK = '{KIND_NAME, 32'h0, 32'h0, 3'd0, 1'b1, ST_OK};

    localparam int DIR_ROWS = 28;
    localparam int RANDOM_WORDS = 900;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    spirv_entry_point_extractor_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Parser state mirrored by the predictor.
    logic [2:0]  hdr_seen;
    logic [15:0] words_left;
    logic [15:0] word_index;
    logic        in_entry;
    logic        name_done;
    status_t     sticky_err;

    result_t     pending_records[$];
    word_row_t   cur_row;
    word_row_t   dir_tab [DIR_ROWS];
    logic [31:0] mod_words[$];
    result_t     want_r;
    result_t     got_r;
    bit          calm_tx;

    int n_fail;
    int n_words;
    int n_modules;
    int n_entries;
    int n_chunks;
    int n_end_status [5];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: stream stopped moving, %0d records still pending",
                 pending_records.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: advance the mirrored parse state by one word and return the
    // result item it should produce.
    // ------------------------------------------------------------------------
    function automatic result_t predict_record(input logic [31:0] w, input logic lst);
        result_t     r;
        logic [15:0] wc;
        logic [15:0] idx;
        bit          nul;
        r = '0;
        if (sticky_err == ST_RUNNING)
        begin
            if (hdr_seen < HEADER_WORDS)
            begin
                if (hdr_seen == 3'd0 && w != SPV_MAGIC)
                    sticky_err = ST_BAD_HEADER;
                else
                    hdr_seen = hdr_seen + 3'd1;
            end
            else if (words_left == 16'd0)
            begin
                // instruction start: count in the high half, opcode in the low
                wc = w[31:16];
                if (wc == 16'd0)
                    sticky_err = ST_ZERO_COUNT;
                else
                begin
                    words_left = wc - 16'd1;
                    word_index = 16'd1;
                    in_entry   = (w[15:0] == OP_ENTRY_POINT) && (wc >= MIN_ENTRY_WORDS);
                    name_done  = 1'b0;
                end
            end
            else
            begin
                idx        = word_index;
                words_left = words_left - 16'd1;
                word_index = idx + 16'd1;
                if (in_entry)
                begin
                    if (idx == MODEL_WORD)
                    begin
                        r.record_kind     = KIND_ENTRY;
                        r.execution_model = w;
                    end
                    else if (idx >= NAME_FIRST_WORD && !name_done)
                    begin
                        // copy bytes up to the first NUL, low byte first
                        nul = 1'b0;
                        for (int b = 0; b < 4; b++)
                        begin
                            if (!nul)
                            begin
                                if (w[8*b +: 8] == 8'h00)
                                    nul = 1'b1;
                                else
                                begin
                                    r.name_chars[8*b +: 8] = w[8*b +: 8];
                                    r.char_count = r.char_count + 3'd1;
                                end
                            end
                        end
                        r.record_kind = KIND_NAME;
                        if (nul || words_left == 16'd0)
                        begin
                            r.name_complete = 1'b1;
                            name_done       = 1'b1;
                        end
                    end
                end
            end
            if (lst && sticky_err == ST_RUNNING)
            begin
                if (hdr_seen < HEADER_WORDS)
                    sticky_err = ST_BAD_HEADER;
                else if (words_left != 16'd0)
                    sticky_err = ST_OVERRUN;
            end
        end

        if (sticky_err != ST_RUNNING)
            r.status = sticky_err;
        else if (lst)
            r.status = ST_OK;
        else
            r.status = ST_RUNNING;

        // an overrun keeps the record formed on the final word; other errors drop it
        if (sticky_err != ST_RUNNING && sticky_err != ST_OVERRUN)
        begin
            r.record_kind     = KIND_NONE;
            r.execution_model = '0;
            r.name_chars      = '0;
            r.char_count      = '0;
            r.name_complete   = 1'b0;
        end

        if (lst)
        begin
            hdr_seen   = '0;
            words_left = '0;
            word_index = '0;
            in_entry   = 1'b0;
            name_done  = 1'b0;
            sticky_err = ST_RUNNING;
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            n_fail++;
            if (n_fail < 50)
                $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predict on every accepted input item, check every accepted
    // result item against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            want_r = predict_record(s_tdata, s_tlast);
            if (cur_row.fixed)
                want_r = cur_row.want;
            pending_records.insert(pending_records.size(), want_r);
            n_words++;
            if (want_r.record_kind == KIND_ENTRY)
                n_entries++;
            if (want_r.record_kind == KIND_NAME)
                n_chunks++;
            if (s_tlast)
            begin
                n_modules++;
                n_end_status[want_r.status]++;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.record_kind     = record_kind_t'(m_tuser);
            got_r.execution_model = m_tdata[31:0];
            got_r.name_chars      = m_tdata[63:32];
            got_r.char_count      = m_tdata[66:64];
            got_r.name_complete   = m_tlast;
            got_r.status          = status_t'(m_tdata[69:67]);
            if (pending_records.size() == 0)
            begin
                n_fail++;
                $display("%0t: result item with nothing expected, expected none, got %h",
                         $time, got_r);
            end
            else
            begin
                want_r = pending_records.pop_front();
                check_field("record_kind", 32'(want_r.record_kind),
                            32'(got_r.record_kind));
                check_field("execution_model", want_r.execution_model,
                            got_r.execution_model);
                check_field("name_chars", want_r.name_chars, got_r.name_chars);
                check_field("char_count", 32'(want_r.char_count), 32'(got_r.char_count));
                check_field("name_complete", 32'(want_r.name_complete),
                            32'(got_r.name_complete));
                check_field("status", 32'(want_r.status), 32'(got_r.status));
                check_field("tdata pad", 32'h0, 32'(m_tdata[71:70]));
            end
        end
    end

    // Receiver pacing: random stalls, with calm stretches of steady ready.
    initial
    begin : rx_pacer
        int  gap;
        int  span;
        bit  calm_rx;
        m_tready = 1'b0;
        span     = 0;
        calm_rx  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span <= 0)
            begin
                calm_rx = ($urandom_range(0, 3) == 0);
                span    = $urandom_range(40, 200);
            end
            gap = pick_gap(calm_rx);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            span = span - gap - 1;
        end
    end

    // Present one word on the slave side and hold it until it is taken.
    // Called and returns at a falling edge.
    task automatic present_word(input word_row_t row);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row = row;
        s_tvalid <= 1'b1;
        s_tdata  <= row.word;
        s_tlast  <= row.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Append one word to the module under construction.
    task automatic append_word(input logic [31:0] w);
        mod_words.insert(mod_words.size(), w);
    endtask

    // Build one random module into mod_words. Mostly well formed: magic,
    // header, a handful of instructions with entry points common. The rest
    // hits bad magic, short headers, zero counts, overruns and cut streams.
    task automatic gen_module();
        int          roll;
        int          wc;
        int          nul_at;
        int          n_name;
        int          cut;
        bit          stop;
        logic [31:0] v;
        logic [15:0] op;
        mod_words.delete();
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            v = $urandom();
            if (v == SPV_MAGIC)
                v[0] = ~v[0];
            append_word(v);
            repeat ($urandom_range(0, 3)) append_word($urandom());
            return;
        end
        append_word(SPV_MAGIC);
        if (roll < 8)
        begin
            repeat ($urandom_range(0, 3)) append_word($urandom());
            return;
        end
        repeat (4) append_word($urandom());

        stop = 1'b0;
        for (int k = $urandom_range(1, 8); k > 0 && !stop; k--)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                // entry point: model, id, then name words, usually with a NUL somewhere
                wc = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(4, 8);
                append_word({wc[15:0], OP_ENTRY_POINT});
                case ($urandom_range(0, 9))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    default: v = $urandom();
                endcase
                append_word(v);
                append_word($urandom());
                n_name = 4 * (wc - 3);
                nul_at = ($urandom_range(0, 3) == 0) ? n_name : $urandom_range(0, n_name - 1);
                for (int j = 0; j < wc - 3; j++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (4*j + b < nul_at)
                            v[8*b +: 8] = 8'($urandom_range(1, 255));
                        else if (4*j + b == nul_at)
                            v[8*b +: 8] = 8'h00;
                        else
                            v[8*b +: 8] = 8'($urandom_range(0, 255));
                    end
                    append_word(v);
                end
            end
            else if (roll < 53)
            begin
                // entry opcode but too short to count as one
                wc = $urandom_range(1, 3);
                append_word({wc[15:0], OP_ENTRY_POINT});
                repeat (wc - 1) append_word($urandom());
            end
            else if (roll < 90)
            begin
                wc = $urandom_range(1, 6);
                op = 16'($urandom_range(0, 65535));
                if (op == OP_ENTRY_POINT)
                    op = op + 16'd1;
                append_word({wc[15:0], op});
                repeat (wc - 1) append_word($urandom());
            end
            else if (roll < 95)
            begin
                // zero word count, then trailing words under the sticky error
                op = 16'($urandom_range(0, 65535));
                append_word({16'h0000, op});
                repeat ($urandom_range(0, 3)) append_word($urandom());
                stop = 1'b1;
            end
            else
            begin
                // huge count that the stream never finishes
                wc = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(16'h8000, 16'hFFFE);
                op = ($urandom_range(0, 1) == 0) ? OP_ENTRY_POINT : 16'($urandom());
                append_word({wc[15:0], op});
                repeat ($urandom_range(1, 4)) append_word($urandom());
                stop = 1'b1;
            end
        end

        // now and then end the stream at an arbitrary word
        if (!stop && mod_words.size() > 6 && $urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(5, mod_words.size() - 2);
            while (mod_words.size() > cut + 1)
                void'(mod_words.pop_back());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        word_row_t row;
        int        sent;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cur_row    = '0;
        calm_tx    = 1'b0;
        hdr_seen   = '0;
        words_left = '0;
        word_index = '0;
        in_entry   = 1'b0;
        name_done  = 1'b0;
        sticky_err = ST_RUNNING;
        n_fail     = 0;
        n_words    = 0;
        n_modules  = 0;
        n_entries  = 0;
        n_chunks   = 0;
        for (int i = 0; i < 5; i++)
            n_end_status[i] = 0;

        dir_tab = '{
            // bad magic, then the error holds through the final word
            '{32'h0723_0202, 1'b0, 1'b1, RES_BAD_HDR},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, RES_BAD_HDR},
            // header cut short right after the magic
            '{SPV_MAGIC,     1'b1, 1'b1, RES_BAD_HDR},
            // entry point whose name word is the final word: overrun
            '{SPV_MAGIC,     1'b0, 1'b1, RES_IDLE},
            '{32'h0001_0500, 1'b0, 1'b0, RES_IDLE},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0000, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0000, 1'b0, 1'b0, RES_IDLE},
            '{32'h0006_000F, 1'b0, 1'b0, RES_IDLE},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0001, 1'b0, 1'b0, RES_IDLE},
            '{32'h6E69_616D, 1'b1, 1'b1, RES_CUT_MAIN},
            // four-word entry point with an empty name, ends cleanly
            '{SPV_MAGIC,     1'b0, 1'b0, RES_IDLE},
            '{32'h0001_0600, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0000, 1'b0, 1'b0, RES_IDLE},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0000, 1'b0, 1'b0, RES_IDLE},
            '{32'h0004_000F, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0000, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_0002, 1'b0, 1'b0, RES_IDLE},
            '{32'hFFFF_FF00, 1'b1, 1'b1, RES_EMPTY_OK},
            // zero word count, then a maximum-count word under the sticky error
            '{SPV_MAGIC,     1'b0, 1'b0, RES_IDLE},
            '{32'h1234_5678, 1'b0, 1'b0, RES_IDLE},
            '{32'h8765_4321, 1'b0, 1'b0, RES_IDLE},
            '{32'hA5A5_A5A5, 1'b0, 1'b0, RES_IDLE},
            '{32'h5A5A_5A5A, 1'b0, 1'b0, RES_IDLE},
            '{32'h0000_FFFF, 1'b0, 1'b1, RES_ZERO_CNT},
            '{32'hFFFF_000F, 1'b1, 1'b1, RES_ZERO_CNT}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            present_word(dir_tab[i]);

        // hold off the sender until every result of the table is back
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        @(negedge clk);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            gen_module();
            calm_tx = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < mod_words.size(); i++)
            begin
                row.word  = mod_words[i];
                row.last  = (i == mod_words.size() - 1);
                row.fixed = 1'b0;
                row.want  = RES_IDLE;
                present_word(row);
            end
            sent += mod_words.size();
        end

        // drain, then give the pipeline time to show any stray result
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d words in %0d modules: %0d entry points, %0d name chunks.",
                 n_words, n_modules, n_entries, n_chunks);
        $display("Module endings: ok %0d, bad header %0d, zero count %0d, overrun %0d.",
                 n_end_status[ST_OK], n_end_status[ST_BAD_HEADER],
                 n_end_status[ST_ZERO_COUNT], n_end_status[ST_OVERRUN]);
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
